[rtl/pesh_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pesh_pkg: shared constants and types of the peri-event spike histogram
// Sizes, field widths, command codes and the controller/datapath interface.
// ----------------------------------------------------------------------------
package pesh_pkg;

   // sizing
   localparam int MAX_BINS      = 1024;
   localparam int ELECTRODES    = 16;
   localparam int UNIT_SLOTS    = 8;
   localparam int TRIGGER_DEPTH = 16;
   localparam int SPIKE_DEPTH   = 64;

   localparam int ROWS       = ELECTRODES * UNIT_SLOTS;
   localparam int HIST_DEPTH = ROWS * MAX_BINS;
   localparam int HADDR_W    = $clog2(HIST_DEPTH);
   localparam int BIN_W      = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
   localparam int NB_W       = $clog2(MAX_BINS + 1);
   localparam int TIDX_W     = (TRIGGER_DEPTH > 1) ? $clog2(TRIGGER_DEPTH) : 1;
   localparam int SIDX_W     = (SPIKE_DEPTH > 1) ? $clog2(SPIKE_DEPTH) : 1;
   localparam int TFILL_W    = $clog2(TRIGGER_DEPTH + 1);
   localparam int SFILL_W    = $clog2(SPIKE_DEPTH + 1);
   localparam int IDX_W0     = (TIDX_W > SIDX_W) ? TIDX_W : SIDX_W;
   localparam int IDX_W      = (IDX_W0 > BIN_W) ? IDX_W0 : BIN_W;

   // field widths
   localparam int TS_W     = 48;
   localparam int CFG_W    = 20;
   localparam int TSRC_W   = 5;
   localparam int LINE_W   = 8;
   localparam int SRC_W    = 4;
   localparam int ELEC_W   = 4;
   localparam int UNIT_W   = 3;
   localparam int BIDX_W   = 10;
   localparam int ACT_W    = 3;
   localparam int CSR_IDX_W = 3;
   localparam int CNT_W    = 32;
   localparam int MEAN_W   = 40;
   localparam int SUM_W    = CNT_W + BIN_W;
   localparam int DIV_W    = SUM_W + 8;
   localparam int STEP_W   = $clog2(DIV_W + 1);
   localparam int SREC_W   = TS_W + ELEC_W + UNIT_W;

   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   // register reset values
   localparam logic [CFG_W-1:0]  WINDOW_RESET = 20'd30000;
   localparam logic [CFG_W-1:0]  BINSZ_RESET  = 20'd300;
   localparam logic [TSRC_W-1:0] TSRC_RESET   = 5'h1F;
   localparam logic [LINE_W-1:0] TLINE_RESET  = 8'd0;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BINSZ  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TSRC   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TLINE  = 3'd3;

   typedef enum logic [ACT_W-1:0] {
      ACT_TRIGGER    = 3'd0,
      ACT_SPIKE      = 3'd1,
      ACT_READ_BIN   = 3'd2,
      ACT_READ_STATS = 3'd3,
      ACT_CLEAR      = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      DIV_PAIR = 2'd0,
      DIV_BINS = 2'd1,
      DIV_MEAN = 2'd2
   } div_mode_type;

   typedef enum logic [1:0] {
      RD_HIT  = 2'd0,
      RD_BIN  = 2'd1,
      RD_STAT = 2'd2
   } rd_sel_type;

   // controller to datapath
   typedef struct packed {
      logic         load_req;
      logic         idx_clr;
      logic         idx_inc;
      logic         ring_rd;
      logic         off_load;
      logic         div_start;
      div_mode_type div_mode;
      logic         bin_load;
      logic         nb_load;
      logic         hist_rd;
      rd_sel_type   rd_sel;
      logic         hist_unit;
      logic         hist_wr;
      logic         push;
      logic         acc_init;
      logic         acc_en;
      logic         rsp_bin;
      logic         rsp_stat;
      logic         clr_start;
      logic         clr_wr;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [ACT_W-1:0] act;
      logic             trig_ok;
      logic             row_ok;
      logic             bin_ok;
      logic             scan_empty;
      logic             scan_last;
      logic             bin_last;
      logic             in_range;
      logic             unit_nz;
      logic             div_done;
      logic             clr_last;
      logic             dirty;
   } dp_status_type;

endpackage
`default_nettype wire

[rtl/pesh_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pesh_div: restoring divider, one quotient bit per cycle
// The dividend is loaded left aligned; after the given number of steps the
// quotient register holds the whole quotient.
// ----------------------------------------------------------------------------
module pesh_div import pesh_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIV_W-1:0]  dividend,
   input  logic [CFG_W-1:0]  divisor,
   input  logic [STEP_W-1:0] steps,
   output logic              done,
   output logic [DIV_W-1:0]  quotient
);

   logic [CFG_W-1:0]  rem_ff, rem_in;
   logic [DIV_W-1:0]  q_ff, q_in;
   logic [CFG_W-1:0]  dvs_ff, dvs_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              done_ff, done_in;
   logic [CFG_W:0]    trial;
   logic              ge;

   // one trial subtraction per step
   always_comb begin
      trial  = {rem_ff, q_ff[DIV_W-1]};
      ge     = trial >= {1'b0, dvs_ff};
      rem_in = rem_ff;
      q_in   = q_ff;
      dvs_in = dvs_ff;
      cnt_in = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         q_in   = dividend;
         dvs_in = divisor;
         cnt_in = steps;
      end else if (cnt_ff != '0) begin
         rem_in  = ge ? CFG_W'(trial - {1'b0, dvs_ff}) : trial[CFG_W-1:0];
         q_in    = {q_ff[DIV_W-2:0], ge};
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == STEP_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      q_ff   <= q_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule
`default_nettype wire

[rtl/pesh_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pesh_dp: datapath of the peri-event spike histogram
// Registers, trigger and spike rings, histogram memory, offset and bin
// arithmetic, row statistics and result registers.
// ----------------------------------------------------------------------------
module pesh_dp import pesh_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  ctrl_cmd_type         cmd,
   output dp_status_type        st,
   input  logic [ACT_W-1:0]     req_action,
   input  logic [TS_W-1:0]      req_timestamp,
   input  logic [SRC_W-1:0]     req_source,
   input  logic [LINE_W-1:0]    req_line,
   input  logic                 req_rising,
   input  logic [ELEC_W-1:0]    req_electrode,
   input  logic [UNIT_W-1:0]    req_sorted_unit,
   input  logic [BIDX_W-1:0]    req_bin_index,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata,
   output logic [CNT_W-1:0]     rsp_bin_count,
   output logic [CNT_W-1:0]     rsp_min_count,
   output logic [CNT_W-1:0]     rsp_max_count,
   output logic [MEAN_W-1:0]    rsp_mean_q8,
   output logic [NB_W-1:0]      rsp_bins_used
);

   // registers
   logic [CFG_W-1:0]  window_ff, window_in, binsz_ff, binsz_in;
   logic [TSRC_W-1:0] tsrc_ff, tsrc_in;
   logic [LINE_W-1:0] tline_ff, tline_in;
   logic              dirty_ff, dirty_in, changed;

   // latched request
   logic [ACT_W-1:0]  act_ff;
   logic [TS_W-1:0]   ts_ff;
   logic [SRC_W-1:0]  src_ff;
   logic [LINE_W-1:0] line_ff;
   logic              rise_ff;
   logic [ELEC_W-1:0] elec_ff;
   logic [UNIT_W-1:0] unit_ff;
   logic [BIDX_W-1:0] bidx_ff;

   // rings
   logic [TS_W-1:0]    trig_mem [TRIGGER_DEPTH];
   logic [SREC_W-1:0]  spk_mem  [SPIKE_DEPTH];
   logic [TS_W-1:0]    trig_q_ff;
   logic [SREC_W-1:0]  spk_q_ff;
   logic [TIDX_W-1:0]  thead_ff, thead_in;
   logic [SIDX_W-1:0]  shead_ff, shead_in;
   logic [TFILL_W-1:0] tfill_ff, tfill_in;
   logic [SFILL_W-1:0] sfill_ff, sfill_in;

   // scan and pair
   logic [IDX_W-1:0]   idx_ff;
   logic [CFG_W-1:0]   pos_ff;
   logic               in_range_ff;
   logic [ELEC_W-1:0]  pe_ff;
   logic [UNIT_W-1:0]  pu_ff;
   logic [BIN_W-1:0]   bin_ff;
   logic [NB_W-1:0]    nb_ff;

   // histogram
   logic [CNT_W-1:0]   hist_mem [HIST_DEPTH];
   logic [CNT_W-1:0]   hist_q_ff;
   logic [HADDR_W-1:0] clr_addr_ff;
   logic [HADDR_W-1:0] hit_addr, req_row_addr, raddr, waddr;
   logic [CNT_W-1:0]   wdata;

   // statistics
   logic [CNT_W-1:0]   min_ff, max_ff;
   logic [SUM_W-1:0]   sum_ff;

   // divider
   logic [DIV_W-1:0]   dvd, quo;
   logic [CFG_W-1:0]   dvs;
   logic [STEP_W-1:0]  steps;
   logic               div_done;

   // misc
   logic [CFG_W-1:0]   eff_bin, half;
   logic               row_ok, bin_ok, trig_ok;
   logic [31:0]        scan_fill;
   logic [TS_W-1:0]    s_ts, t_ts, d;
   logic               ge;
   logic [ELEC_W-1:0]  pe_in;
   logic [UNIT_W-1:0]  pu_in;

   // register writes; a changed value requests a clearing pass
   always_comb begin
      window_in = window_ff;
      binsz_in  = binsz_ff;
      tsrc_in   = tsrc_ff;
      tline_in  = tline_ff;
      changed   = 1'b0;
      if (csr_write) begin
         unique case (csr_index)
            CSR_WINDOW: if (csr_wdata != window_ff) begin
               window_in = csr_wdata;
               changed   = 1'b1;
            end
            CSR_BINSZ: if (csr_wdata != binsz_ff) begin
               binsz_in = csr_wdata;
               changed  = 1'b1;
            end
            CSR_TSRC: if (csr_wdata[TSRC_W-1:0] != tsrc_ff) begin
               tsrc_in = csr_wdata[TSRC_W-1:0];
               changed = 1'b1;
            end
            CSR_TLINE: if (csr_wdata[LINE_W-1:0] != tline_ff) begin
               tline_in = csr_wdata[LINE_W-1:0];
               changed  = 1'b1;
            end
            default: ;
         endcase
      end
      dirty_in = changed | (dirty_ff & ~cmd.clr_start);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
         binsz_ff  <= BINSZ_RESET;
         tsrc_ff   <= TSRC_RESET;
         tline_ff  <= TLINE_RESET;
         dirty_ff  <= 1'b0;
      end else begin
         window_ff <= window_in;
         binsz_ff  <= binsz_in;
         tsrc_ff   <= tsrc_in;
         tline_ff  <= tline_in;
         dirty_ff  <= dirty_in;
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         act_ff  <= req_action;
         ts_ff   <= req_timestamp;
         src_ff  <= req_source;
         line_ff <= req_line;
         rise_ff <= req_rising;
         elec_ff <= req_electrode;
         unit_ff <= req_sorted_unit;
         bidx_ff <= req_bin_index;
      end
   end

   // request qualifiers
   always_comb begin
      eff_bin = (binsz_ff == '0) ? CFG_W'(1) : binsz_ff;
      half    = window_ff >> 1;
      row_ok  = (32'(elec_ff) < 32'(ELECTRODES)) && (32'(unit_ff) < 32'(UNIT_SLOTS));
      bin_ok  = row_ok && (32'(bidx_ff) < 32'(nb_ff));
      trig_ok = ~tsrc_ff[TSRC_W-1] && (src_ff == tsrc_ff[SRC_W-1:0])
                && (line_ff == tline_ff) && rise_ff;
      scan_fill = (act_ff == ACT_TRIGGER) ? 32'(sfill_ff) : 32'(tfill_ff);
   end

   // ring heads and fill counts
   always_comb begin
      thead_in = thead_ff;
      shead_in = shead_ff;
      tfill_in = tfill_ff;
      sfill_in = sfill_ff;
      if (cmd.clr_start) begin
         thead_in = '0;
         shead_in = '0;
         tfill_in = '0;
         sfill_in = '0;
      end else if (cmd.push) begin
         if (act_ff == ACT_TRIGGER) begin
            thead_in = (32'(thead_ff) == 32'(TRIGGER_DEPTH - 1)) ? '0 : thead_ff + 1'b1;
            if (32'(tfill_ff) < 32'(TRIGGER_DEPTH)) tfill_in = tfill_ff + 1'b1;
         end else begin
            shead_in = (32'(shead_ff) == 32'(SPIKE_DEPTH - 1)) ? '0 : shead_ff + 1'b1;
            if (32'(sfill_ff) < 32'(SPIKE_DEPTH)) sfill_in = sfill_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thead_ff <= '0;
         shead_ff <= '0;
         tfill_ff <= '0;
         sfill_ff <= '0;
      end else begin
         thead_ff <= thead_in;
         shead_ff <= shead_in;
         tfill_ff <= tfill_in;
         sfill_ff <= sfill_in;
      end
   end

   // ring memories, registered read
   always_ff @(posedge clock) begin
      if (cmd.push && act_ff == ACT_TRIGGER) trig_mem[thead_ff] <= ts_ff;
      if (cmd.push && act_ff != ACT_TRIGGER) spk_mem[shead_ff] <= {ts_ff, elec_ff, unit_ff};
      if (cmd.ring_rd) begin
         trig_q_ff <= trig_mem[idx_ff[TIDX_W-1:0]];
         spk_q_ff  <= spk_mem[idx_ff[SIDX_W-1:0]];
      end
   end

   // scan index
   always_ff @(posedge clock) begin
      if (reset || cmd.idx_clr) idx_ff <= '0;
      else if (cmd.idx_inc)     idx_ff <= idx_ff + 1'b1;
   end

   // pair offset and window test
   always_comb begin
      if (act_ff == ACT_TRIGGER) begin
         s_ts  = spk_q_ff[SREC_W-1 -: TS_W];
         t_ts  = ts_ff;
         pe_in = spk_q_ff[UNIT_W +: ELEC_W];
         pu_in = spk_q_ff[UNIT_W-1:0];
      end else begin
         s_ts  = ts_ff;
         t_ts  = trig_q_ff;
         pe_in = elec_ff;
         pu_in = unit_ff;
      end
      ge = s_ts >= t_ts;
      d  = ge ? s_ts - t_ts : t_ts - s_ts;
   end

   always_ff @(posedge clock) begin
      if (cmd.off_load) begin
         in_range_ff <= d <= TS_W'(half);
         pos_ff      <= ge ? half + d[CFG_W-1:0] : half - d[CFG_W-1:0];
         pe_ff       <= pe_in;
         pu_ff       <= pu_in;
      end
   end

   // divider operands
   always_comb begin
      case (cmd.div_mode)
         DIV_BINS: begin
            dvd   = {window_ff, {(DIV_W-CFG_W){1'b0}}};
            dvs   = eff_bin;
            steps = STEP_W'(CFG_W);
         end
         DIV_MEAN: begin
            dvd   = {sum_ff, 8'd0};
            dvs   = CFG_W'(nb_ff);
            steps = STEP_W'(DIV_W);
         end
         default: begin
            dvd   = {pos_ff, {(DIV_W-CFG_W){1'b0}}};
            dvs   = eff_bin;
            steps = STEP_W'(CFG_W);
         end
      endcase
   end

   pesh_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dvd),
      .divisor  (dvs),
      .steps    (steps),
      .done     (div_done),
      .quotient (quo)
   );

   // bin clamp and bins in use
   always_ff @(posedge clock) begin
      if (cmd.bin_load)
         bin_ff <= (quo >= DIV_W'(nb_ff)) ? BIN_W'(nb_ff - 1'b1) : quo[BIN_W-1:0];
      if (cmd.nb_load) begin
         if (quo == '0)                   nb_ff <= NB_W'(1);
         else if (quo > DIV_W'(MAX_BINS)) nb_ff <= NB_W'(MAX_BINS);
         else                             nb_ff <= quo[NB_W-1:0];
      end
   end

   // histogram addressing
   always_comb begin
      hit_addr = HADDR_W'((32'(pe_ff) * 32'(UNIT_SLOTS)
                  + (cmd.hist_unit ? 32'(pu_ff) : 32'd0)) * 32'(MAX_BINS) + 32'(bin_ff));
      req_row_addr = HADDR_W'((32'(elec_ff) * 32'(UNIT_SLOTS) + 32'(unit_ff))
                      * 32'(MAX_BINS));
      case (cmd.rd_sel)
         RD_BIN:  raddr = req_row_addr + HADDR_W'(bidx_ff);
         RD_STAT: raddr = req_row_addr + HADDR_W'(idx_ff);
         default: raddr = hit_addr;
      endcase
      waddr = cmd.clr_wr ? clr_addr_ff : hit_addr;
      wdata = cmd.clr_wr ? '0 : ((hist_q_ff == CNT_MAX) ? hist_q_ff : hist_q_ff + 1'b1);
   end

   always_ff @(posedge clock) begin
      if (cmd.clr_wr || cmd.hist_wr) hist_mem[waddr] <= wdata;
      if (cmd.hist_rd) hist_q_ff <= hist_mem[raddr];
   end

   // clearing sweep address
   always_ff @(posedge clock) begin
      if (reset || cmd.clr_start) clr_addr_ff <= '0;
      else if (cmd.clr_wr)        clr_addr_ff <= clr_addr_ff + 1'b1;
   end

   // row statistics
   always_ff @(posedge clock) begin
      if (cmd.acc_init) begin
         min_ff <= CNT_MAX;
         max_ff <= '0;
         sum_ff <= '0;
      end else if (cmd.acc_en) begin
         if (hist_q_ff < min_ff) min_ff <= hist_q_ff;
         if (hist_q_ff > max_ff) max_ff <= hist_q_ff;
         sum_ff <= sum_ff + SUM_W'(hist_q_ff);
      end
   end

   // result registers
   always_ff @(posedge clock) begin
      if (cmd.rsp_bin) begin
         rsp_bin_count <= bin_ok ? hist_q_ff : '0;
         rsp_min_count <= '0;
         rsp_max_count <= '0;
         rsp_mean_q8   <= '0;
         rsp_bins_used <= nb_ff;
      end else if (cmd.rsp_stat) begin
         rsp_bin_count <= '0;
         rsp_min_count <= row_ok ? min_ff : '0;
         rsp_max_count <= row_ok ? max_ff : '0;
         rsp_mean_q8   <= row_ok ? quo[MEAN_W-1:0] : '0;
         rsp_bins_used <= nb_ff;
      end
   end

   // status
   always_comb begin
      st.act        = act_ff;
      st.trig_ok    = trig_ok;
      st.row_ok     = row_ok;
      st.bin_ok     = bin_ok;
      st.scan_empty = scan_fill == 32'd0;
      st.scan_last  = (32'(idx_ff) + 32'd1) == scan_fill;
      st.bin_last   = (32'(idx_ff) + 32'd1) == 32'(nb_ff);
      st.in_range   = in_range_ff;
      st.unit_nz    = pu_ff != '0;
      st.div_done   = div_done;
      st.clr_last   = clr_addr_ff == HADDR_W'(HIST_DEPTH - 1);
      st.dirty      = dirty_ff;
   end

endmodule
`default_nettype wire

[rtl/pesh_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pesh_ctrl: sequencer of the peri-event spike histogram
// Steps clearing, ring scans, pair binning, reads and statistics.
// ----------------------------------------------------------------------------
module pesh_ctrl import pesh_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   output logic          rsp_valid,
   input  dp_status_type st,
   output ctrl_cmd_type  cmd
);

   typedef enum logic [4:0] {
      S_CLEAR, S_BINS, S_BWAIT, S_IDLE, S_DECODE,
      S_SCAN_RD, S_SCAN_OFF, S_SCAN_CHK, S_DIV_WAIT,
      S_HIT_RD, S_HIT_WR, S_UNIT_RD, S_UNIT_WR, S_NEXT, S_PUSH,
      S_RB_RD, S_RB_OUT, S_ST_RD, S_ST_ACC, S_ST_DIV, S_ST_WAIT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (st.clr_last) state_in = S_BINS;
         end
         S_BINS: begin
            cmd.div_start = 1'b1;
            cmd.div_mode  = DIV_BINS;
            state_in      = S_BWAIT;
         end
         S_BWAIT: begin
            if (st.div_done) begin
               cmd.nb_load = 1'b1;
               state_in    = S_IDLE;
            end
         end
         S_IDLE: begin
            if (st.dirty) begin
               cmd.clr_start = 1'b1;
               state_in      = S_CLEAR;
            end else if (start) begin
               cmd.load_req = 1'b1;
               state_in     = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.idx_clr = 1'b1;
            state_in    = S_IDLE;
            unique case (st.act)
               ACT_TRIGGER, ACT_SPIKE: begin
                  if ((st.act == ACT_TRIGGER) ? st.trig_ok : st.row_ok)
                     state_in = st.scan_empty ? S_PUSH : S_SCAN_RD;
               end
               ACT_READ_BIN: begin
                  if (st.bin_ok) state_in = S_RB_RD;
                  else cmd.rsp_bin = 1'b1;
               end
               ACT_READ_STATS: begin
                  cmd.acc_init = 1'b1;
                  if (st.row_ok) state_in = S_ST_RD;
                  else cmd.rsp_stat = 1'b1;
               end
               ACT_CLEAR: begin
                  cmd.clr_start = 1'b1;
                  state_in      = S_CLEAR;
               end
               default: ;
            endcase
         end
         S_SCAN_RD: begin
            cmd.ring_rd = 1'b1;
            state_in    = S_SCAN_OFF;
         end
         S_SCAN_OFF: begin
            cmd.off_load = 1'b1;
            state_in     = S_SCAN_CHK;
         end
         S_SCAN_CHK: begin
            if (st.in_range) begin
               cmd.div_start = 1'b1;
               cmd.div_mode  = DIV_PAIR;
               state_in      = S_DIV_WAIT;
            end else begin
               state_in = S_NEXT;
            end
         end
         S_DIV_WAIT: begin
            if (st.div_done) begin
               cmd.bin_load = 1'b1;
               state_in     = S_HIT_RD;
            end
         end
         S_HIT_RD: begin
            cmd.hist_rd = 1'b1;
            cmd.rd_sel  = RD_HIT;
            state_in    = S_HIT_WR;
         end
         S_HIT_WR: begin
            cmd.hist_wr = 1'b1;
            state_in    = st.unit_nz ? S_UNIT_RD : S_NEXT;
         end
         S_UNIT_RD: begin
            cmd.hist_rd   = 1'b1;
            cmd.rd_sel    = RD_HIT;
            cmd.hist_unit = 1'b1;
            state_in      = S_UNIT_WR;
         end
         S_UNIT_WR: begin
            cmd.hist_wr   = 1'b1;
            cmd.hist_unit = 1'b1;
            state_in      = S_NEXT;
         end
         S_NEXT: begin
            if (st.scan_last) begin
               state_in = S_PUSH;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_SCAN_RD;
            end
         end
         S_PUSH: begin
            cmd.push = 1'b1;
            state_in = S_IDLE;
         end
         S_RB_RD: begin
            cmd.hist_rd = 1'b1;
            cmd.rd_sel  = RD_BIN;
            state_in    = S_RB_OUT;
         end
         S_RB_OUT: begin
            cmd.rsp_bin = 1'b1;
            state_in    = S_IDLE;
         end
         S_ST_RD: begin
            cmd.hist_rd = 1'b1;
            cmd.rd_sel  = RD_STAT;
            state_in    = S_ST_ACC;
         end
         S_ST_ACC: begin
            cmd.acc_en = 1'b1;
            if (st.bin_last) begin
               state_in = S_ST_DIV;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_ST_RD;
            end
         end
         S_ST_DIV: begin
            cmd.div_start = 1'b1;
            cmd.div_mode  = DIV_MEAN;
            state_in      = S_ST_WAIT;
         end
         S_ST_WAIT: begin
            if (st.div_done) begin
               cmd.rsp_stat = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      rsp_valid_in = cmd.rsp_bin | cmd.rsp_stat;
   end

   // state and result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = (state_ff != S_IDLE) | st.dirty;
   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

[rtl/peri_event_spike_histogram_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// peri_event_spike_histogram_unit: peri-event spike histogram
// Pairs spikes with trigger times and keeps saturating bin counts per row.
// ----------------------------------------------------------------------------
// Usage:
//  - A command transfer happens at a clock edge with start high and busy low.
//    Actions: trigger event, spike, read bin, read row statistics, clear.
//  - Read commands give one result on the rsp_ ports for a single cycle,
//    marked by rsp_valid; the receiver cannot hold it off and need not.
//  - The user writes registers over the csr_ port (ready always high) only
//    while idle; the block does not enforce it. Changes start a clearing pass.
// Sequence, one command at a time:
//  - trigger or spike: each stored entry of the other ring is read and its
//    offset tested; a pair in the window is binned by the bin divider and
//    counted in unit 0's row and, if sorted, its unit's row; the event is stored.
//  - read bin: one histogram read; read statistics: each bin in use is read
//    through the single histogram read port, then the mean divider runs.
//  - out-of-range reads and rejected events finish in the decode state.
// Reset, clear command and register change: a clearing pass writes every
// histogram entry, then bins in use is recomputed; busy stays high throughout.
// ----------------------------------------------------------------------------
module peri_event_spike_histogram_unit import pesh_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [ACT_W-1:0]     req_action,
   input  logic [TS_W-1:0]      req_timestamp,
   input  logic [SRC_W-1:0]     req_source,
   input  logic [LINE_W-1:0]    req_line,
   input  logic                 req_rising,
   input  logic [ELEC_W-1:0]    req_electrode,
   input  logic [UNIT_W-1:0]    req_sorted_unit,
   input  logic [BIDX_W-1:0]    req_bin_index,
   output logic                 rsp_valid,
   output logic [CNT_W-1:0]     rsp_bin_count,
   output logic [CNT_W-1:0]     rsp_min_count,
   output logic [CNT_W-1:0]     rsp_max_count,
   output logic [MEAN_W-1:0]    rsp_mean_q8,
   output logic [NB_W-1:0]      rsp_bins_used,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   ctrl_cmd_type  cmd;
   dp_status_type st;

   assign csr_ready = 1'b1;

   pesh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .st        (st),
      .cmd       (cmd)
   );

   pesh_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .st              (st),
      .req_action      (req_action),
      .req_timestamp   (req_timestamp),
      .req_source      (req_source),
      .req_line        (req_line),
      .req_rising      (req_rising),
      .req_electrode   (req_electrode),
      .req_sorted_unit (req_sorted_unit),
      .req_bin_index   (req_bin_index),
      .csr_write       (csr_valid & csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_bin_count   (rsp_bin_count),
      .rsp_min_count   (rsp_min_count),
      .rsp_max_count   (rsp_max_count),
      .rsp_mean_q8     (rsp_mean_q8),
      .rsp_bins_used   (rsp_bins_used)
   );

`ifndef SYNTHESIS
   // a result never lasts more than one cycle
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for two cycles");

   // no result in the cycle after a command transfer
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> !rsp_valid)
      else $error("result too soon after command transfer");

   // every count increment follows its read
   a_rmw_order: assert property (@(posedge clock) disable iff (reset)
      cmd.hist_wr |-> $past(cmd.hist_rd))
      else $error("histogram increment without preceding read");
`endif

endmodule
`default_nettype wire
